>>> rtl/ssr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ssr_pkg;

   localparam int MAX_DIM         = 64;
   localparam int STORE_DEPTH     = 4096;
   localparam int SCREEN_WIDTH    = 128;
   localparam logic [15:0] TRANSPARENT_KEY = 16'd63519;

   localparam int ADDR_W = 12;
   localparam int OFF_W  = 13;
   localparam int DIM_W  = 7;

   // register indexes on the configuration port
   localparam logic [2:0] REG_X_ORIGIN  = 3'd0;
   localparam logic [2:0] REG_SPRITE_Y  = 3'd1;
   localparam logic [2:0] REG_Y_SCROLL  = 3'd2;
   localparam logic [2:0] REG_SRC_W     = 3'd3;
   localparam logic [2:0] REG_SRC_H     = 3'd4;
   localparam logic [2:0] REG_TGT_W     = 3'd5;
   localparam logic [2:0] REG_TGT_H     = 3'd6;
   localparam logic [2:0] REG_FLAGS     = 3'd7;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_RENDER = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [11:0]       pixel_address;
      logic [15:0]       pixel_value;
      logic [6:0]        line_number;
   } req_type;

   typedef struct packed {
      logic [6:0]        screen_x;
      logic [15:0]       color;
      logic              write_enable;
      logic              last;
   } rsp_type;

   function automatic logic [DIM_W-1:0] clamp_src(input logic [DIM_W-1:0] v);
      if (v == '0) return DIM_W'(1);
      if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
      return v;
   endfunction

   function automatic logic [DIM_W-1:0] clamp_tgt(input logic [DIM_W-1:0] v);
      if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
      return v;
   endfunction

endpackage
`default_nettype wire

>>> rtl/ssr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ssr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/ssr_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ssr_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        go,
   input  wire logic [12:0] num,
   input  wire logic [6:0]  den,
   output logic             done,
   output logic [12:0]      quot,
   output logic [6:0]       rem
);
   import ssr_pkg::*;

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [12:0] quo_ff, quo_in;
   logic [6:0]  rem_ff, rem_in;
   logic [7:0]  trial;
   logic        ge;

   // restoring division, one quotient bit a cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[12]};
      ge      = trial >= {1'b0, den};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (go) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = num;
         rem_in = '0;
      end else if (run_ff) begin
         rem_in = ge ? 7'(trial - {1'b0, den}) : trial[6:0];
         quo_in = {quo_ff[11:0], ge};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd12) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;
endmodule
`default_nettype wire

>>> rtl/scaled_sprite_scanline_render_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Load item: written into the image store at the accept edge.
// Unscaled render item: each sprite column is read through the store's registered
//   read port; results leave on rsp_valid one cycle each and the receiver cannot stall.
// Scaled render item: mirrored columns wait on the shared divider for the column inside
//   the row; line 0 first runs the divider setup and skips rows hidden above the top edge.
// Synchronous active-high reset clears control and scaling state; image store is not cleared.
module scaled_sprite_scanline_render_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire ssr_pkg::req_type req_data,
   output logic                  rsp_valid,
   output ssr_pkg::rsp_type      rsp_data,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [4:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import ssr_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_START  = 4'd1;
   localparam logic [3:0] S_UBASE  = 4'd2;
   localparam logic [3:0] S_URD    = 4'd3;
   localparam logic [3:0] S_UEMIT  = 4'd4;
   localparam logic [3:0] S_DIV1   = 4'd5;
   localparam logic [3:0] S_DIV1W  = 4'd6;
   localparam logic [3:0] S_MUL    = 4'd7;
   localparam logic [3:0] S_DIV2   = 4'd8;
   localparam logic [3:0] S_DIV2W  = 4'd9;
   localparam logic [3:0] S_SKCOL  = 4'd10;
   localparam logic [3:0] S_SKROW  = 4'd11;
   localparam logic [3:0] S_CHECK  = 4'd12;
   localparam logic [3:0] S_SCOL   = 4'd13;
   localparam logic [3:0] S_MWAIT  = 4'd14;
   localparam logic [3:0] S_SEMIT  = 4'd15;

   // configuration registers
   logic [8:0] xo_ff;
   logic [7:0] sy_ff, scr_ff;
   logic [6:0] sw_ff, sh_ff, tw_reg_ff, th_reg_ff;
   logic [1:0] flag_ff;

   // scaling state, kept across items
   logic [12:0] off_ff, off_in;
   logic [6:0]  rerr_ff, rerr_in;
   logic [6:0]  cstep_ff, cstep_in;
   logic [6:0]  crem_ff, crem_in;
   logic [12:0] rskip_ff, rskip_in;
   logic [6:0]  rrem_ff, rrem_in;

   // per-item control
   logic [3:0]  state_ff, state_in;
   logic [6:0]  line_ff, line_in;
   logic [6:0]  x_ff, x_in;
   logic [6:0]  xe_ff, xe_in;
   logic [7:0]  k_ff, k_in;
   logic [12:0] base_ff, base_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [6:0]  w, h, tw, th;
   logic        scaled, mirror;
   logic signed [10:0] cur;
   logic        cur_in_h, cur_in_th;
   logic [7:0]  nsy;
   logic        accept, csr_write;

   logic        ram_we;
   logic [11:0] ram_raddr;
   logic [15:0] ram_rdata;

   logic        div_go, div_done;
   logic [12:0] div_num, div_quot;
   logic [6:0]  div_den, div_rem;

   logic [12:0] col_off, row_off;
   logic [6:0]  col_xe, row_err;
   logic [7:0]  xs, rs;
   logic [9:0]  tx;
   logic        on_screen;
   logic [6:0]  col_ix;
   logic [13:0] mir_addr, prod;

   assign accept    = start && !busy;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         xo_ff     <= '0;
         sy_ff     <= '0;
         scr_ff    <= '0;
         sw_ff     <= 7'd1;
         sh_ff     <= 7'd1;
         tw_reg_ff <= '0;
         th_reg_ff <= '0;
         flag_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[4:2])
            REG_X_ORIGIN: xo_ff     <= csr_pwdata[8:0];
            REG_SPRITE_Y: sy_ff     <= csr_pwdata[7:0];
            REG_Y_SCROLL: scr_ff    <= csr_pwdata[7:0];
            REG_SRC_W:    sw_ff     <= csr_pwdata[6:0];
            REG_SRC_H:    sh_ff     <= csr_pwdata[6:0];
            REG_TGT_W:    tw_reg_ff <= csr_pwdata[6:0];
            REG_TGT_H:    th_reg_ff <= csr_pwdata[6:0];
            REG_FLAGS:    flag_ff   <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_X_ORIGIN: csr_prdata = {23'd0, xo_ff};
         REG_SPRITE_Y: csr_prdata = {24'd0, sy_ff};
         REG_Y_SCROLL: csr_prdata = {24'd0, scr_ff};
         REG_SRC_W:    csr_prdata = {25'd0, sw_ff};
         REG_SRC_H:    csr_prdata = {25'd0, sh_ff};
         REG_TGT_W:    csr_prdata = {25'd0, tw_reg_ff};
         REG_TGT_H:    csr_prdata = {25'd0, th_reg_ff};
         REG_FLAGS:    csr_prdata = {30'd0, flag_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // User must keep config stable while busy (unenforced); clamped values use the registers.
   assign w      = clamp_src(sw_ff);
   assign h      = clamp_src(sh_ff);
   assign tw     = clamp_tgt(tw_reg_ff);
   assign th     = clamp_tgt(th_reg_ff);
   assign scaled = (tw != '0) && (th != '0);
   assign mirror = flag_ff[1];
   assign cur    = $signed({4'd0, line_ff}) - $signed({{3{sy_ff[7]}}, sy_ff})
                   - $signed({{3{scr_ff[7]}}, scr_ff});
   assign cur_in_h  = !cur[10] && (cur[9:0] < {3'd0, h});
   assign cur_in_th = !cur[10] && (cur[9:0] < {3'd0, th});
   assign nsy    = 8'(-sy_ff);

   // One column step of the Bresenham walk
   always_comb begin
      xs      = {1'b0, xe_ff} + {1'b0, crem_ff};
      col_off = off_ff + {6'd0, cstep_ff};
      col_xe  = xs[6:0];
      if (xs >= {1'b0, tw}) begin
         col_xe  = 7'(xs - {1'b0, tw});
         col_off = col_off + 13'd1;
      end
   end

   // One row step
   always_comb begin
      rs      = {1'b0, rerr_ff} + {1'b0, rrem_ff};
      row_off = off_ff + rskip_ff;
      if (rs >= {1'b0, th}) begin
         rs      = rs - {1'b0, th};
         row_off = row_off + {6'd0, w};
      end
      row_err = rs[6:0];
   end

   assign tx        = {3'd0, x_ff} + {xo_ff[8], xo_ff};
   assign on_screen = !tx[9] && (tx[8:0] < 9'(SCREEN_WIDTH));
   assign col_ix    = mirror ? 7'(w - 7'd1 - x_ff) : x_ff;
   // reflect the column inside the current source row
   assign mir_addr  = {1'b0, div_num} - {7'd0, div_rem} + {7'd0, w} - 14'd1
                      - {7'd0, div_rem};
   assign prod      = {7'd0, div_quot[6:0]} * {7'd0, w};

   assign div_go  = (state_ff == S_DIV1) || (state_ff == S_DIV2)
                    || ((state_ff == S_SCOL) && mirror);
   // hold the operands for the whole division
   always_comb begin
      div_num = off_ff;
      div_den = w;
      if ((state_ff == S_DIV1) || (state_ff == S_DIV1W)) begin
         div_num = {6'd0, h};
         div_den = th;
      end else if ((state_ff == S_DIV2) || (state_ff == S_DIV2W)) begin
         div_num = {6'd0, w};
         div_den = tw;
      end
   end

   always_comb begin
      state_in     = state_ff;
      line_in      = line_ff;
      x_in         = x_ff;
      xe_in        = xe_ff;
      k_in         = k_ff;
      base_in      = base_ff;
      off_in       = off_ff;
      rerr_in      = rerr_ff;
      cstep_in     = cstep_ff;
      crem_in      = crem_ff;
      rskip_in     = rskip_ff;
      rrem_in      = rrem_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_raddr    = off_ff[11:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_data.kind == KIND_RENDER && flag_ff[0]) begin
               line_in  = req_data.line_number;
               state_in = S_START;
            end
         end
         S_START: begin
            x_in  = '0;
            xe_in = '0;
            if (!scaled) begin
               state_in = cur_in_h ? S_UBASE : S_IDLE;
            end else if (line_ff == '0) begin
               state_in = S_DIV1;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_UBASE: begin
            base_in  = {7'd0, cur[5:0]} * {6'd0, w};
            state_in = S_URD;
         end
         S_URD: begin
            ram_raddr = 12'(base_ff + {6'd0, col_ix});
            state_in  = S_UEMIT;
         end
         S_UEMIT: begin
            rsp_valid_in = 1'b1;
            rsp_in.write_enable = on_screen && (ram_rdata != TRANSPARENT_KEY);
            rsp_in.screen_x = rsp_in.write_enable ? tx[6:0] : '0;
            rsp_in.color    = rsp_in.write_enable ? ram_rdata : '0;
            rsp_in.last     = (x_ff == 7'(w - 7'd1));
            x_in     = x_ff + 7'd1;
            state_in = rsp_in.last ? S_IDLE : S_URD;
         end
         S_DIV1:  state_in = S_DIV1W;
         S_DIV1W: if (div_done) state_in = S_MUL;
         S_MUL: begin
            rskip_in = 13'(prod - {7'd0, w});
            rrem_in  = div_rem;
            state_in = S_DIV2;
         end
         S_DIV2:  state_in = S_DIV2W;
         S_DIV2W: begin
            if (div_done) begin
               cstep_in = div_quot[6:0];
               crem_in  = div_rem;
               off_in   = '0;
               rerr_in  = '0;
               k_in     = '0;
               state_in = sy_ff[7] ? S_SKCOL : S_CHECK;
            end
         end
         S_SKCOL: begin
            off_in = col_off;
            xe_in  = col_xe;
            x_in   = x_ff + 7'd1;
            if (x_ff == 7'(tw - 7'd1)) state_in = S_SKROW;
         end
         S_SKROW: begin
            off_in  = row_off;
            rerr_in = row_err;
            x_in    = '0;
            xe_in   = '0;
            k_in    = k_ff + 8'd1;
            state_in = (k_ff == 8'(nsy - 8'd1)) ? S_CHECK : S_SKCOL;
         end
         S_CHECK: begin
            x_in     = '0;
            xe_in    = '0;
            state_in = cur_in_th ? S_SCOL : S_IDLE;
         end
         S_SCOL: begin
            // mirrored columns hold the read until the divider gives the column in the row
            ram_raddr = off_ff[11:0];
            state_in  = mirror ? S_MWAIT : S_SEMIT;
         end
         S_MWAIT: begin
            ram_raddr = mir_addr[11:0];
            if (div_done) state_in = S_SEMIT;
         end
         S_SEMIT: begin
            rsp_valid_in = 1'b1;
            rsp_in.write_enable = on_screen && (ram_rdata != TRANSPARENT_KEY);
            rsp_in.screen_x = rsp_in.write_enable ? tx[6:0] : '0;
            rsp_in.color    = rsp_in.write_enable ? ram_rdata : '0;
            rsp_in.last     = (x_ff == 7'(tw - 7'd1));
            off_in   = col_off;
            xe_in    = col_xe;
            x_in     = x_ff + 7'd1;
            state_in = rsp_in.last ? S_START : S_SCOL;
            if (rsp_in.last) begin
               // finish the line with a row step, then drop to idle
               off_in   = col_off;
               state_in = S_SKROW;
               k_in     = 8'd0;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Row step after the last scaled column goes through S_SKROW; finish_ff marks it
   // so that the step exits straight to idle.
   logic finish_ff, finish_in;
   always_comb begin
      finish_in = finish_ff;
      if (state_ff == S_SEMIT && rsp_in.last) finish_in = 1'b1;
      if (state_ff == S_SKROW) finish_in = 1'b0;
   end

   logic [3:0] state_next;
   always_comb begin
      state_next = state_in;
      if (state_ff == S_SKROW && finish_ff) state_next = S_IDLE;
   end

   // the row step after the final column applies to the offset after that column
   logic [12:0] off_next;
   always_comb begin
      off_next = off_in;
      if (state_ff == S_SKROW && finish_ff) off_next = row_off;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         finish_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         off_ff       <= '0;
         rerr_ff      <= '0;
         cstep_ff     <= '0;
         crem_ff      <= '0;
         rskip_ff     <= '0;
         rrem_ff      <= '0;
      end else begin
         state_ff     <= state_next;
         finish_ff    <= finish_in;
         rsp_valid_ff <= rsp_valid_in;
         off_ff       <= off_next;
         rerr_ff      <= rerr_in;
         cstep_ff     <= cstep_in;
         crem_ff      <= crem_in;
         rskip_ff     <= rskip_in;
         rrem_ff      <= rrem_in;
      end
      line_ff <= line_in;
      x_ff    <= x_in;
      xe_ff   <= xe_in;
      k_ff    <= k_in;
      base_ff <= base_in;
      rsp_ff  <= rsp_in;
   end

   assign ram_we = accept && (req_data.kind == KIND_LOAD)
                   && ({1'b0, req_data.pixel_address} < 13'(STORE_DEPTH));

   ssr_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_data.pixel_address),
      .wr_data (req_data.pixel_value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ssr_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_rsp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.write_enable |-> rsp_data.screen_x == '0 && rsp_data.color == '0)
      else $error("disabled result carries data");
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid)
      else $error("result follows the last of a line");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> busy)
      else $error("result while idle");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !div_go)
      else $error("divider started while idle");
`endif
endmodule
`default_nettype wire

>>> tb/scaled_sprite_scanline_render_unit_tb.sv
`timescale 1ns / 1ps
module scaled_sprite_scanline_render_unit_tb;
   import ssr_pkg::*;

   // sprite registers and scaling accumulators, kept as raw register bits
   typedef struct {
      logic [8:0]  x_origin;
      logic [7:0]  sprite_y;
      logic [7:0]  y_scroll;
      logic [6:0]  src_w;
      logic [6:0]  src_h;
      logic [6:0]  tgt_w;
      logic [6:0]  tgt_h;
      logic [1:0]  flags;
      logic [12:0] offset;
      logic [6:0]  row_err;
      logic [6:0]  col_step;
      logic [6:0]  col_rem;
      logic [12:0] row_skip;
      logic [6:0]  row_rem;
   } sprite_state_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // live state follows accepted items; plan state follows the generator
   sprite_state_type live_state;
   sprite_state_type plan_state;
   logic [15:0]   image_pixels [STORE_DEPTH];
   bit            pixel_loaded [STORE_DEPTH];

   req_type pending_items [$];
   rsp_type expected_pixels [$];
   int      mismatch_count = 0;
   int      gap_left = 0;
   bit      no_gaps = 0;
   logic    drive_next;

   scaled_sprite_scanline_render_unit uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic sprite_state_type reset_state();
      sprite_state_type s;
      s = '{default: '0};
      s.src_w = 7'd1;
      s.src_h = 7'd1;
      return s;
   endfunction

   // advance the source offset by one destination column
   function automatic void step_column(inout sprite_state_type s, inout int xe,
                                       input int tw);
      s.offset = s.offset + 13'(s.col_step);
      xe += s.col_rem;
      if (xe >= tw) begin
         xe -= tw;
         s.offset = s.offset + 13'd1;
      end
   endfunction

   // advance to the next destination row; the remainder carries whole source rows
   function automatic void step_row(inout sprite_state_type s, input int w, input int th);
      int re;
      s.offset = s.offset + s.row_skip;
      re = s.row_err + s.row_rem;
      if (re >= th) begin
         re -= th;
         s.offset = s.offset + 13'(w);
      end
      s.row_err = 7'(re);
   endfunction

   // work out the store addresses and screen columns of one render item
   function automatic void render_columns(inout sprite_state_type s, input logic [6:0] line,
                                          output int addrs[$], output int cols[$]);
      int w, h, tw, th, xo, sy, cur, xe, off, col;
      bit mirror;
      addrs = {};
      cols = {};
      if (!s.flags[0]) return;
      w  = (s.src_w == 0) ? 1 : (s.src_w > MAX_DIM ? MAX_DIM : s.src_w);
      h  = (s.src_h == 0) ? 1 : (s.src_h > MAX_DIM ? MAX_DIM : s.src_h);
      tw = s.tgt_w > MAX_DIM ? MAX_DIM : s.tgt_w;
      th = s.tgt_h > MAX_DIM ? MAX_DIM : s.tgt_h;
      xo = $signed(s.x_origin);
      sy = $signed(s.sprite_y);
      cur = int'(line) - sy - int'($signed(s.y_scroll));
      mirror = s.flags[1];
      if (tw == 0 || th == 0) begin
         if (cur < 0 || cur >= h) return;
         for (int x = 0; x < w; x++) begin
            addrs.push_back(((mirror ? w - 1 - x : x) + cur * w) % STORE_DEPTH);
            cols.push_back(x + xo);
         end
         return;
      end
      // line 0 reloads the accumulators and skips rows hidden above the top edge
      if (line == 0) begin
         s.row_skip = 13'((h / th) * w + 8192 - w);
         s.row_rem  = 7'(h % th);
         s.col_step = 7'(w / tw);
         s.col_rem  = 7'(w % tw);
         s.row_err  = '0;
         s.offset   = '0;
         for (int k = 0; k < -sy; k++) begin
            xe = 0;
            for (int x = 0; x < tw; x++) step_column(s, xe, tw);
            step_row(s, w, th);
         end
      end
      if (cur < 0 || cur >= th) return;
      xe = 0;
      for (int x = 0; x < tw; x++) begin
         off = s.offset;
         col = off % w;
         addrs.push_back((mirror ? off - col + (w - 1 - col) : off) % STORE_DEPTH);
         cols.push_back(x + xo);
         step_column(s, xe, tw);
      end
      step_row(s, w, th);
   endfunction

   // predict the results of an accepted item
   function automatic void predict_item(input req_type it);
      int addrs[$], cols[$];
      rsp_type r;
      logic [15:0] c;
      bit on;
      if (it.kind == KIND_LOAD) begin
         image_pixels[it.pixel_address] = it.pixel_value;
         return;
      end
      render_columns(live_state, it.line_number, addrs, cols);
      foreach (addrs[k]) begin
         c  = image_pixels[addrs[k]];
         on = cols[k] >= 0 && cols[k] < SCREEN_WIDTH && c != TRANSPARENT_KEY;
         r.screen_x     = on ? 7'(cols[k]) : 7'd0;
         r.color        = on ? c : 16'd0;
         r.write_enable = on;
         r.last         = (k == addrs.size() - 1);
         expected_pixels.push_back(r);
      end
   endfunction

   // driver: present pending items with random gaps, or none when no_gaps is set
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         drive_next = start;
         if (start && !busy) begin
            predict_item(req_data);
            drive_next = 1'b0;
            gap_left = no_gaps ? 0 : $urandom_range(0, 5);
         end
         if (!drive_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() > 0) begin
               req_data <= pending_items.pop_front();
               drive_next = 1'b1;
            end
         end
         start <= drive_next;
      end
   end

   // monitor: compare each strobed result with the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result x=%0d color=%h", rsp_data.screen_x, rsp_data.color);
            mismatch_count++;
         end else begin
            e = expected_pixels.pop_front();
            if (rsp_data.screen_x !== e.screen_x) begin
               $error("screen_x expected %0d actual %0d", e.screen_x, rsp_data.screen_x);
               mismatch_count++;
            end
            if (rsp_data.color !== e.color) begin
               $error("color expected %h actual %h", e.color, rsp_data.color);
               mismatch_count++;
            end
            if (rsp_data.write_enable !== e.write_enable) begin
               $error("write_enable expected %b actual %b", e.write_enable,
                      rsp_data.write_enable);
               mismatch_count++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last expected %b actual %b", e.last, rsp_data.last);
               mismatch_count++;
            end
         end
      end
   end

   // write one register through setup and access cycles; mirror it into both states
   task automatic csr_write(input logic [2:0] idx, input int value);
      logic [8:0] v;
      v = 9'(value);
      case (idx)
         REG_X_ORIGIN: begin
            live_state.x_origin = v;
            plan_state.x_origin = v;
         end
         REG_SPRITE_Y: begin
            live_state.sprite_y = v[7:0];
            plan_state.sprite_y = v[7:0];
         end
         REG_Y_SCROLL: begin
            live_state.y_scroll = v[7:0];
            plan_state.y_scroll = v[7:0];
         end
         REG_SRC_W: begin
            live_state.src_w = v[6:0];
            plan_state.src_w = v[6:0];
         end
         REG_SRC_H: begin
            live_state.src_h = v[6:0];
            plan_state.src_h = v[6:0];
         end
         REG_TGT_W: begin
            live_state.tgt_w = v[6:0];
            plan_state.tgt_w = v[6:0];
         end
         REG_TGT_H: begin
            live_state.tgt_h = v[6:0];
            plan_state.tgt_h = v[6:0];
         end
         default: begin
            live_state.flags = v[1:0];
            plan_state.flags = v[1:0];
         end
      endcase
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {23'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic queue_load(input int addr, input logic [15:0] value);
      req_type it;
      it.kind          = KIND_LOAD;
      it.pixel_address = 12'(addr);
      it.pixel_value   = value;
      it.line_number   = 7'($urandom);
      pixel_loaded[addr] = 1'b1;
      pending_items.push_back(it);
   endtask

   // queue a render item; load first any store entry it would read unwritten
   task automatic queue_render(input int line);
      sprite_state_type trial;
      int addrs[$], cols[$];
      req_type it;
      trial = plan_state;
      render_columns(trial, 7'(line), addrs, cols);
      foreach (addrs[k])
         if (!pixel_loaded[addrs[k]])
            queue_load(addrs[k], ($urandom_range(0, 5) == 0) ? TRANSPARENT_KEY : 16'($urandom));
      plan_state = trial;
      it.kind          = KIND_RENDER;
      it.pixel_address = 12'($urandom);
      it.pixel_value   = 16'($urandom);
      it.line_number   = 7'(line);
      pending_items.push_back(it);
   endtask

   // hold until the block is idle with nothing outstanding
   task automatic drain();
      wait (pending_items.size() == 0 && !start);
      @(posedge clock);
      wait (!busy && expected_pixels.size() == 0);
      repeat (50) @(posedge clock);
   endtask

   task automatic configure(input int phase);
      int vals[8];
      case (phase)
         0: vals = '{0, 0, 0, 4, 4, 0, 0, 1};
         1: vals = '{-256, -128, 127, 0, 127, 127, 64, 3};
         2: vals = '{255, 127, -128, 64, 64, 64, 1, 1};
         3: vals = '{-3, -2, 0, 64, 3, 0, 0, 3};
         4: vals = '{120, 0, 0, 5, 7, 64, 127, 0};
         default: begin
            vals[0] = $urandom_range(0, 9) == 0 ? $urandom_range(0, 511)
                                                : $urandom_range(0, 140) - 20;
            vals[1] = $urandom_range(0, 16) - 8;
            vals[2] = $urandom_range(0, 8) - 4;
            vals[3] = $urandom_range(0, 9) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 8);
            vals[4] = $urandom_range(0, 9) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 8);
            vals[5] = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
            vals[6] = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
            if ($urandom_range(0, 9) == 0) vals[5] = $urandom_range(0, 127);
            vals[7] = $urandom_range(0, 7) == 0 ? 2 * $urandom_range(0, 1)
                                                : 1 + 2 * $urandom_range(0, 1);
         end
      endcase
      for (int i = 0; i < 8; i++) csr_write(3'(i), vals[i]);
   endtask

   initial begin
      int line;
      live_state = reset_state();
      plan_state = reset_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 10; phase++) begin
         if (phase > 0) drain();
         configure(phase);
         no_gaps = ($urandom_range(0, 3) == 0);
         if (phase == 0) begin
            // store extremes, both ends of the line range
            queue_load(0, 16'h0000);
            queue_load(STORE_DEPTH - 1, 16'hffff);
            queue_load(1, TRANSPARENT_KEY);
            queue_load(2, 16'h5555);
            queue_load(3, 16'haaaa);
            queue_render(0);
            queue_render(127);
         end
         // mostly consecutive lines from the top, so scaling walks whole sprites
         line = 0;
         for (int n = 0; n < 14; n++) begin
            if ($urandom_range(0, 4) == 0) begin
               queue_load($urandom_range(0, STORE_DEPTH - 1),
                          $urandom_range(0, 3) == 0 ? TRANSPARENT_KEY : 16'($urandom));
            end else if ($urandom_range(0, 4) == 0) begin
               queue_render($urandom_range(0, 127));
            end else begin
               queue_render(line);
               line = line + ($urandom_range(0, 5) == 0 ? 2 : 1);
            end
         end
      end
      drain();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> files.f
rtl/ssr_pkg.sv
rtl/ssr_ram.sv
rtl/ssr_div.sv
rtl/scaled_sprite_scanline_render_unit.sv
tb/scaled_sprite_scanline_render_unit_tb.sv
